// ===== src/bf16at_pkg.sv =====
// Package with the bfloat16 and binary32 field constants for the truncating adder.
package bf16at_pkg;

    // bfloat16 word layout.
    localparam int unsigned BfWidth   = 16;
    localparam int unsigned ExpWidth  = 8;
    localparam int unsigned FracWidth = 7;

    // Binary32 significand with hidden bit, plus guard, round and sticky bits.
    localparam int unsigned SigWidth  = 24;
    localparam int unsigned GrsWidth  = 3;
    localparam int unsigned AlnWidth  = SigWidth + GrsWidth;
    localparam int unsigned SumWidth  = AlnWidth + 1;
    localparam int unsigned LowZeros  = AlnWidth - (FracWidth + 1);

    localparam logic [ExpWidth-1:0]  ExpMax     = '1;
    localparam logic [BfWidth-1:0]   DefaultNan = 16'h7FC0;
    localparam logic [FracWidth-1:0] QuietBit   = 7'h40;

endpackage

// ===== src/bf16_add_truncate_top.sv =====
// Top level of the bfloat16 adder that sums through binary32 and truncates the result.
// A transaction taken at a clock edge is held in the input registers, and its result then
// passes through the result registers, which drive o_valid and o_sum_bits.
// Throughput: one transaction per cycle; busy stays low, the input and result registers
// let every cycle carry a new operand pair.
// Reset: synchronous, active low; it clears only the valid flags of both register stages.
// The receiver cannot stall, so each result is on the ports for exactly one cycle.
module bf16_add_truncate_top
    import bf16at_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [BfWidth-1:0] i_addend_a,
    input  logic [BfWidth-1:0] i_addend_b,
    output logic               o_valid,
    output logic [BfWidth-1:0] o_sum_bits
);

    logic               r_in_vld;
    logic [BfWidth-1:0] r_a;
    logic [BfWidth-1:0] r_b;
    logic               r_out_vld;
    logic [BfWidth-1:0] r_sum;
    logic [BfWidth-1:0] n_sum;

    assign busy       = 1'b0;
    assign o_valid    = r_out_vld;
    assign o_sum_bits = r_sum;

    // Valid flags of the two register stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_out_vld <= r_in_vld;
        end
    end

    // Operand and result registers.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_a <= i_addend_a;
            r_b <= i_addend_b;
        end
        r_sum <= n_sum;
    end

    logic [ExpWidth-1:0]  ea, eb, ex, ey, ex1, ey1, d;
    logic [FracWidth-1:0] fa, fb;
    logic                 sa, sb, sx, sy, swap, lost, rnd_up;
    logic [BfWidth-1:0]   x, y;
    logic [FracWidth:0]   mx, my;
    logic [AlnWidth-1:0]  wx, wy_full, wy_sh, wy;
    logic [SumWidth-1:0]  r_raw, r_nrm;
    logic [9:0]           e, e_lim;
    logic [4:0]           lz;
    logic [9:0]           sh;
    logic [SigWidth:0]    mant;
    logic [GrsWidth-1:0]  rem;

    // Add, normalize and round as binary32, then keep the upper half.
    always_comb begin
        ea = r_a[14:7];
        eb = r_b[14:7];
        fa = r_a[6:0];
        fb = r_b[6:0];
        sa = r_a[15];
        sb = r_b[15];

        // Order the operands so that x has the larger magnitude.
        swap = r_b[14:0] > r_a[14:0];
        x    = swap ? r_b : r_a;
        y    = swap ? r_a : r_b;
        sx   = x[15];
        sy   = y[15];
        ex   = x[14:7];
        ey   = y[14:7];
        mx   = {ex != '0, x[6:0]};
        my   = {ey != '0, y[6:0]};
        ex1  = (ex == '0) ? 8'd1 : ex;
        ey1  = (ey == '0) ? 8'd1 : ey;
        d    = ex1 - ey1;

        // Align the smaller operand, folding shifted-out bits into sticky.
        wx      = {mx, {LowZeros{1'b0}}};
        wy_full = {my, {LowZeros{1'b0}}};
        wy_sh   = wy_full >> d;
        lost    = (wy_sh << d) != wy_full;
        if (d >= 8'(AlnWidth)) begin
            wy = {{(AlnWidth-1){1'b0}}, my != '0};
        end else begin
            wy = {wy_sh[AlnWidth-1:1], wy_sh[0] | lost};
        end

        r_raw = (sx == sy) ? ({1'b0, wx} + {1'b0, wy}) : ({1'b0, wx} - {1'b0, wy});

        // Leading-zero count below the carry position.
        lz = '0;
        for (int i = 0; i < AlnWidth; i++) begin
            if (r_raw[i]) begin
                lz = 5'(AlnWidth - 1 - i);
            end
        end

        // Normalize: a carry shifts right, a cancellation shifts left down to the minimum exponent.
        e     = {2'b00, ex1};
        e_lim = e - 10'd1;
        sh    = ({5'b0, lz} < e_lim) ? {5'b0, lz} : e_lim;
        if (r_raw[SumWidth-1]) begin
            r_nrm = {1'b0, r_raw[SumWidth-1:2], r_raw[1] | r_raw[0]};
            e     = e + 10'd1;
        end else begin
            r_nrm = r_raw << sh;
            e     = e - sh;
        end

        // Round to nearest even at the binary32 significand.
        rem    = r_nrm[GrsWidth-1:0];
        rnd_up = (rem > 3'b100) || ((rem == 3'b100) && r_nrm[GrsWidth]);
        mant   = {1'b0, r_nrm[AlnWidth-1:GrsWidth]} + {{SigWidth{1'b0}}, rnd_up};
        if (mant[SigWidth]) begin
            mant = mant >> 1;
            e    = e + 10'd1;
        end

        // Special operands take priority over the arithmetic path.
        if (ea == ExpMax && fa != '0) begin
            n_sum = r_a | {{(BfWidth-FracWidth){1'b0}}, QuietBit};
        end else if (eb == ExpMax && fb != '0) begin
            n_sum = r_b | {{(BfWidth-FracWidth){1'b0}}, QuietBit};
        end else if (ea == ExpMax && eb == ExpMax) begin
            n_sum = (sa == sb) ? r_a : DefaultNan;
        end else if (ea == ExpMax) begin
            n_sum = r_a;
        end else if (eb == ExpMax) begin
            n_sum = r_b;
        end else if (r_raw == '0) begin
            n_sum = {sx & sy, 15'b0};
        end else if (e >= 10'd255) begin
            n_sum = {sx, ExpMax, 7'b0};
        end else begin
            n_sum = {sx, mant[SigWidth-1] ? e[7:0] : 8'd0, mant[22:16]};
        end
    end

    // An accepted transaction raises o_valid after passing the input and result registers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted transaction produced no result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_vld))
        else $error("result strobe without a transaction in the input stage");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |-> $past(start))
        else $error("input stage valid without a start");

endmodule
